// ===== hdl/tcpq_pkg.sv =====
package tcpq_pkg;

  localparam int unsigned CAP_BITS     = 4;
  localparam int unsigned FILL_BITS    = 4;
  localparam int unsigned OUT_TAG_BITS = 32;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 4'd8;

  typedef enum logic {
    ACT_PUSH = 1'b0,
    ACT_POP  = 1'b1
  } action_e;

  typedef enum logic {
    CLS_HIGH = 1'b0,
    CLS_LOW  = 1'b1
  } class_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // decoded command handed from the front to the back
  typedef struct packed {
    action_e act;
    class_e  cls;
  } cmd_ctl_t;

endpackage

// ===== hdl/tcpq_req_if.sv =====
interface tcpq_req_if #(
  parameter int unsigned TAG_BITS = 32
) ();
  logic                valid;
  logic                ready;
  logic                action;
  logic                priority_req;
  logic [TAG_BITS-1:0] message_tag;

  modport source (output valid, action, priority_req, message_tag, input ready);
  modport sink   (input valid, action, priority_req, message_tag, output ready);
endinterface

// ===== hdl/tcpq_rsp_if.sv =====
interface tcpq_rsp_if import tcpq_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              status;
  logic [OUT_TAG_BITS-1:0] popped_tag;
  logic                    popped_priority;
  logic [FILL_BITS-1:0]    fill_count;

  modport source (output valid, status, popped_tag, popped_priority, fill_count,
                  input ready);
  modport sink   (input valid, status, popped_tag, popped_priority, fill_count,
                  output ready);
endinterface

// ===== hdl/tcpq_front.sv =====
module tcpq_front import tcpq_pkg::*; #(
  parameter int unsigned TAG_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  tcpq_req_if.sink            req_i,
  output logic                cmd_valid_o,
  input  logic                cmd_ready_i,
  output cmd_ctl_t            cmd_ctl_o,
  output logic [TAG_BITS-1:0] cmd_tag_o
);

  // two-entry command queue
  cmd_ctl_t            ctl_q [2];
  logic [TAG_BITS-1:0] tag_q [2];
  logic                wptr_q, rptr_q;
  logic [1:0]          cnt_q, cnt_d;
  logic                push, pop;
  cmd_ctl_t            ctl_in;

  assign req_i.ready = (cnt_q != 2'd2);
  assign push        = req_i.valid && req_i.ready;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_ctl_o   = ctl_q[rptr_q];
  assign cmd_tag_o   = tag_q[rptr_q];

  always_comb begin
    ctl_in.act = action_e'(req_i.action);
    ctl_in.cls = class_e'(req_i.priority_req);
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 2'd0;
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ctl_q[wptr_q] <= ctl_in;
      tag_q[wptr_q] <= req_i.message_tag;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("command queue count out of range");
`endif

endmodule

// ===== hdl/tcpq_back.sv =====
module tcpq_back import tcpq_pkg::*; #(
  parameter int unsigned DEPTH    = 8,
  parameter int unsigned TAG_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CAP_BITS-1:0] cfg_wdata_i,
  input  logic                cmd_valid_i,
  output logic                cmd_ready_o,
  input  cmd_ctl_t            cmd_ctl_i,
  input  logic [TAG_BITS-1:0] cmd_tag_i,
  tcpq_rsp_if.source          rsp_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned LW = (CW > CAP_BITS) ? CW : CAP_BITS;

  // ordered store, front at slot 0, highs ahead of lows
  logic [TAG_BITS-1:0] tag_q [DEPTH];
  logic [TAG_BITS-1:0] tag_d [DEPTH];
  logic [TAG_BITS-1:0] tag_up [DEPTH];
  logic [TAG_BITS-1:0] tag_dn [DEPTH];
  logic [DEPTH-1:0]    cls_q, cls_d, cls_up, cls_dn;

  logic [CW-1:0]       cnt_q, cnt_d, high_q, high_d, pos;
  logic [CAP_BITS-1:0] cap_q;
  logic [LW-1:0]       cap_ext, limit, fill_ext;
  logic                take, is_push, full, empty, push_ok, pop_ok;
  status_e             status;
  logic [63:0]         front_tag_w;

  logic                           out_vld_q;
  logic [1:0]                     out_status_q;
  logic [OUT_TAG_BITS-1:0]        out_tag_q;
  logic                           out_cls_q;
  logic [FILL_BITS-1:0]           out_fill_q;

  // neighbor taps for the insert and pop shifts
  assign tag_up[0]       = tag_q[0];
  assign cls_up[0]       = cls_q[0];
  assign tag_dn[DEPTH-1] = tag_q[DEPTH-1];
  assign cls_dn[DEPTH-1] = cls_q[DEPTH-1];
  for (genvar gi = 1; gi < DEPTH; gi++) begin : g_tap
    assign tag_up[gi]   = tag_q[gi-1];
    assign cls_up[gi]   = cls_q[gi-1];
    assign tag_dn[gi-1] = tag_q[gi];
    assign cls_dn[gi-1] = cls_q[gi];
  end

  assign cmd_ready_o = !out_vld_q || rsp_o.ready;
  assign take        = cmd_valid_i && cmd_ready_o;

  always_comb begin
    cap_ext = LW'(cap_q);
    limit   = (cap_ext > LW'(DEPTH)) ? LW'(DEPTH) : cap_ext;
    full    = LW'(cnt_q) >= limit;
    empty   = (cnt_q == '0);
    is_push = (cmd_ctl_i.act == ACT_PUSH);
    push_ok = take && is_push && !full;
    pop_ok  = take && !is_push && !empty;
    pos     = (cmd_ctl_i.cls == CLS_HIGH) ? high_q : cnt_q;

    for (int i = 0; i < DEPTH; i++) begin
      tag_d[i] = tag_q[i];
      cls_d[i] = cls_q[i];
      if (push_ok) begin
        if (CW'(i) == pos) begin
          tag_d[i] = cmd_tag_i;
          cls_d[i] = cmd_ctl_i.cls;
        end else if (CW'(i) > pos && CW'(i) <= cnt_q) begin
          tag_d[i] = tag_up[i];
          cls_d[i] = cls_up[i];
        end
      end else if (pop_ok) begin
        tag_d[i] = tag_dn[i];
        cls_d[i] = cls_dn[i];
      end
    end

    cnt_d  = cnt_q;
    high_d = high_q;
    if (push_ok) begin
      cnt_d = cnt_q + CW'(1);
      if (cmd_ctl_i.cls == CLS_HIGH) high_d = high_q + CW'(1);
    end else if (pop_ok) begin
      cnt_d = cnt_q - CW'(1);
      if (cls_q[0] == CLS_HIGH && high_q != '0) high_d = high_q - CW'(1);
    end

    if (is_push) begin
      status = full ? ST_FULL : ST_DONE;
    end else begin
      status = empty ? ST_EMPTY : ST_DONE;
    end
    front_tag_w = 64'(tag_q[0]);
    fill_ext    = LW'(cnt_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      high_q    <= '0;
      cap_q     <= CAP_RESET;
      out_vld_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      high_q <= high_d;
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      if (take) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DEPTH; i++) begin
      tag_q[i] <= tag_d[i];
    end
    cls_q <= cls_d;
    if (take) begin
      out_status_q <= status;
      out_tag_q    <= pop_ok ? front_tag_w[OUT_TAG_BITS-1:0] : '0;
      out_cls_q    <= pop_ok ? cls_q[0] : 1'b0;
      out_fill_q   <= fill_ext[FILL_BITS-1:0];
    end
  end

  assign rsp_o.valid           = out_vld_q;
  assign rsp_o.status          = out_status_q;
  assign rsp_o.popped_tag      = out_tag_q;
  assign rsp_o.popped_priority = out_cls_q;
  assign rsp_o.fill_count      = out_fill_q;

`ifndef NO_ASSERTIONS
  a_high_le_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    high_q <= cnt_q) else $error("high count exceeds item count");
  a_cnt_le_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH)) else $error("item count exceeds depth");
  a_pop_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !is_push && cnt_q != '0) |=> cnt_q == CW'($past(cnt_q) - CW'(1)))
    else $error("pop did not remove one item");
`endif

endmodule

// ===== hdl/two_class_priority_queue.sv =====
// Two-class priority queue.
// req_i (sink): action 0 push / 1 pop, priority_req 0 high / 1 low, message_tag.
//   A pushed high item lands behind stored highs and ahead of all lows; a low
//   item goes to the tail. A pop takes the oldest high, else the oldest low.
// rsp_o (source): one item per request: status (done, full, empty),
//   popped_tag / popped_priority (zero unless a pop succeeded), fill_count.
// cfg_we_i / cfg_wdata_i: capacity register, reset 8, clamped to DEPTH;
//   write it only while no request is in flight.
// Path: a request accepted on req_i is written into the front command queue;
//   when the back takes the command it updates the store and loads the
//   response register at the same edge.
// Throughput: one request per cycle while rsp_o.ready is high; the sustained
//   rate is set by the response register handshake alone.
// Stall: when rsp_o.ready is low the response register holds, the back stops
//   taking commands and the two-entry command queue fills, then req_i.ready
//   drops. Up to three requests can be outstanding.
// Reset: counts cleared and capacity set to 8; the store itself is not
//   cleared, and no slot at or above the fill is ever read.
module two_class_priority_queue import tcpq_pkg::*; #(
  parameter int unsigned DEPTH    = 8,
  parameter int unsigned TAG_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CAP_BITS-1:0] cfg_wdata_i,
  tcpq_req_if.sink            req_i,
  tcpq_rsp_if.source          rsp_o
);

  // front -> back command path
  logic                cmd_valid;
  logic                cmd_ready;
  cmd_ctl_t            cmd_ctl;
  logic [TAG_BITS-1:0] cmd_tag;

  // accept and decode requests into a short command queue
  tcpq_front #(
    .TAG_BITS (TAG_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_ctl_o   (cmd_ctl),
    .cmd_tag_o   (cmd_tag)
  );

  // ordered store, counters, capacity register and response register
  tcpq_back #(
    .DEPTH    (DEPTH),
    .TAG_BITS (TAG_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_ctl_i   (cmd_ctl),
    .cmd_tag_i   (cmd_tag),
    .rsp_o       (rsp_o)
  );

endmodule

// ===== tb/tb_two_class_priority_queue.sv =====
// Testbench for the two-class priority queue.
module tb_two_class_priority_queue import tcpq_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH     = 8;
  localparam int unsigned TAG_BITS  = 32;
  // slack waited after the last owed response before the next step
  localparam int unsigned SETTLE_CYC = 4;

  // one expected response item
  typedef struct packed {
    status_e                 status;
    logic [OUT_TAG_BITS-1:0] tag;
    class_e                  cls;
    logic [FILL_BITS-1:0]    fill;
  } queue_rsp_t;

  logic                clk   = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we;
  logic [CAP_BITS-1:0] cfg_wdata;

  tcpq_req_if #(.TAG_BITS(TAG_BITS)) req_if ();
  tcpq_rsp_if                        rsp_if ();

  two_class_priority_queue #(
    .DEPTH    (DEPTH),
    .TAG_BITS (TAG_BITS)
  ) i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the queue. Front of the queue sits at slot 0; the high
  // items always occupy the first high_cnt slots.
  // ---------------------------------------------------------------------------
  logic [TAG_BITS-1:0] slot_tag [DEPTH];
  class_e              slot_cls [DEPTH];
  int unsigned         stored_cnt  = 0;
  int unsigned         high_cnt    = 0;
  int unsigned         capacity_q  = 32'(CAP_RESET);

  queue_rsp_t  pending_rsp [$];   // responses owed by the block, oldest first
  int unsigned err_cnt       = 0;

  // knobs for the stimulus processes
  int unsigned req_idle_max  = 0;
  int unsigned rsp_idle_max  = 0;
  int unsigned rsp_hold_cyc  = 0;

  // Apply one accepted request to the shadow queue, return the response.
  function automatic queue_rsp_t queue_step(action_e act, class_e cls,
                                            logic [TAG_BITS-1:0] tag);
    queue_rsp_t  r;
    int unsigned limit;
    int unsigned pos;
    r.status = ST_DONE;
    r.tag    = '0;
    r.cls    = CLS_HIGH;
    // capacity beyond the store size is clamped
    limit = (capacity_q > DEPTH) ? DEPTH : capacity_q;
    if (act == ACT_PUSH) begin
      // also covers capacity zero and capacity lowered under the fill
      if (stored_cnt >= limit) begin
        r.status = ST_FULL;
      end else begin
        // high goes behind the other highs, low goes to the tail
        pos = (cls == CLS_HIGH) ? high_cnt : stored_cnt;
        for (int i = stored_cnt; i > pos; i--) begin
          slot_tag[i] = slot_tag[i-1];
          slot_cls[i] = slot_cls[i-1];
        end
        slot_tag[pos] = tag;
        slot_cls[pos] = cls;
        stored_cnt++;
        if (cls == CLS_HIGH) high_cnt++;
      end
    end else begin
      if (stored_cnt == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.tag = slot_tag[0];
        r.cls = slot_cls[0];
        for (int i = 1; i < stored_cnt; i++) begin
          slot_tag[i-1] = slot_tag[i];
          slot_cls[i-1] = slot_cls[i];
        end
        stored_cnt--;
        if (r.cls == CLS_HIGH && high_cnt > 0) high_cnt--;
      end
    end
    r.fill = stored_cnt[FILL_BITS-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: check the response item first, then log the accepted request,
  // so a same-edge push never reorders against the check.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    queue_rsp_t want;
    queue_rsp_t got;
    if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      got = '{status_e'(rsp_if.status), rsp_if.popped_tag,
              class_e'(rsp_if.popped_priority), rsp_if.fill_count};
      if (pending_rsp.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected response status %0d tag %h cls %0d fill %0d",
                 $realtime, got.status, got.tag, got.cls, got.fill);
      end else begin
        want = pending_rsp.pop_front();
        if (got !== want) begin
          err_cnt++;
          $display("%0t: mismatch expected status %0d tag %h cls %0d fill %0d",
                   $realtime, want.status, want.tag, want.cls, want.fill);
          $display("%0t:          actual   status %0d tag %h cls %0d fill %0d",
                   $realtime, got.status, got.tag, got.cls, got.fill);
        end
      end
    end
    if (rst_n && req_if.valid === 1'b1 && req_if.ready === 1'b1) begin
      pending_rsp.push_back(queue_step(action_e'(req_if.action),
                                       class_e'(req_if.priority_req),
                                       req_if.message_tag));
    end
  end

  // ---------------------------------------------------------------------------
  // Response side: random gap before each item, or one long hold when a
  // test asks for it (the hold counts its own cycles here).
  // ---------------------------------------------------------------------------
  initial begin : rsp_sink
    int unsigned gap;
    rsp_if.ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (rsp_hold_cyc > 0) begin
        gap = rsp_hold_cyc;
        rsp_hold_cyc = 0;
      end else begin
        gap = $urandom_range(0, rsp_idle_max);
      end
      if (gap > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1));
    end
  end

  // ---------------------------------------------------------------------------
  // Shared tasks
  // ---------------------------------------------------------------------------

  // Offer one request item, return at the edge where it is taken. valid is
  // left high; the caller either sends again or calls wait_idle right away.
  task automatic send_item(action_e act, class_e cls, logic [TAG_BITS-1:0] tag);
    int unsigned gap;
    gap = $urandom_range(0, req_idle_max);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid        <= 1'b1;
    req_if.action       <= act;
    req_if.priority_req <= cls;
    req_if.message_tag  <= tag;
    do @(posedge clk); while (!(req_if.valid === 1'b1 && req_if.ready === 1'b1));
  endtask

  // Stop offering and wait until every owed response has come back.
  task automatic wait_idle();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (pending_rsp.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Only called with the block idle.
  task automatic write_capacity(logic [CAP_BITS-1:0] cap);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we     <= 1'b0;
    capacity_q = 32'(cap);
  endtask

  task automatic send_random(int unsigned push_pct);
    action_e act;
    act = ($urandom_range(0, 99) < push_pct) ? ACT_PUSH : ACT_POP;
    send_item(act, class_e'($urandom_range(0, 1)), $urandom());
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Ordering at reset capacity: pop on empty, highs jump ahead of lows,
  // extreme tags.
  task automatic test_basic_order();
    send_item(ACT_POP,  CLS_LOW,  32'hFFFF_FFFF);   // refused, empty
    send_item(ACT_PUSH, CLS_LOW,  32'h0000_0000);
    send_item(ACT_PUSH, CLS_LOW,  32'hFFFF_FFFF);
    send_item(ACT_PUSH, CLS_HIGH, 32'hA5A5_5A5A);   // lands ahead of both lows
    send_item(ACT_PUSH, CLS_HIGH, 32'h5A5A_A5A5);   // behind the first high
    repeat (4) send_item(ACT_POP, CLS_HIGH, 32'h0);
    send_item(ACT_POP,  CLS_HIGH, 32'h0);           // empty again
    wait_idle();
  endtask

  // Capacity zero, capacity above the store size, capacity dropped below
  // the current fill.
  task automatic test_capacity_limits();
    write_capacity(4'd0);
    send_item(ACT_PUSH, CLS_HIGH, 32'h1234_5678);   // always refused
    wait_idle();
    write_capacity(4'd15);                          // clamps to DEPTH
    for (int i = 0; i < DEPTH; i++)
      send_item(ACT_PUSH, class_e'(i[0]), $urandom());
    send_item(ACT_PUSH, CLS_HIGH, 32'hFFFF_FFFF);   // full at DEPTH
    wait_idle();
    write_capacity(4'd2);                           // fill 8 stays put
    send_item(ACT_PUSH, CLS_LOW, 32'h0);            // refused
    send_item(ACT_POP,  CLS_LOW, 32'h0);
    send_item(ACT_POP,  CLS_LOW, 32'h0);
    wait_idle();
  endtask

  // Phases of random traffic, each at its own capacity, push bias and idle
  // mix, so the fill walks both to the limit and to empty.
  task automatic test_random_traffic();
    int unsigned cap_plan [11] = '{8, 3, 15, 1, 6, 0, 9, 2, 7, 4, 8};
    int unsigned bias_plan [3] = '{30, 55, 75};
    for (int p = 0; p < 11; p++) begin
      write_capacity(cap_plan[p][CAP_BITS-1:0]);
      req_idle_max = p[0] ? 19 : 0;
      rsp_idle_max = p[1] ? 19 : 0;
      for (int n = 0; n < 100; n++)
        send_random(bias_plan[p % 3]);
      wait_idle();
    end
  endtask

  // Response side holds off for a long stretch while requests keep coming,
  // so the command queue fills and input ready drops. Then the sender
  // pauses until everything is back before a second burst.
  task automatic test_output_stall();
    write_capacity(4'd8);
    req_idle_max = 0;
    rsp_idle_max = 0;
    rsp_hold_cyc = 80;
    for (int n = 0; n < 24; n++)
      send_random(60);
    wait_idle();
    rsp_idle_max = 19;
    for (int n = 0; n < 16; n++)
      send_random(50);
    wait_idle();
  endtask

  initial begin
    cfg_we              <= 1'b0;
    cfg_wdata           <= '0;
    req_if.valid        <= 1'b0;
    req_if.action       <= ACT_PUSH;
    req_if.priority_req <= CLS_HIGH;
    req_if.message_tag  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_order();
    test_capacity_limits();
    test_random_traffic();
    test_output_stall();

    if (err_cnt == 0) begin
      $display("tb_two_class_priority_queue passed");
    end else begin
      $display("tb_two_class_priority_queue failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("tb_two_class_priority_queue failed");
    $finish;
  end

endmodule
